// ===== sv/nbc_pkg.sv =====
package nbc_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int CHROMA_BINS     = 256;
  localparam int CHROMA_W        = 8;
  localparam int LUMA_W          = 8;
  localparam int LABEL_W         = 4;
  localparam int NCLS_W          = 5;
  localparam int KIND_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_Y_UPPER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOWER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_TRAIN = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TRAIN = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [LABEL_W-1:0]  label;
    logic [CHROMA_W-1:0] u;
    logic [CHROMA_W-1:0] v;
    logic [NCLS_W-1:0]   ncls;
    logic                counted;
    logic                label_error;
  } cmd_t;

endpackage

// ===== sv/nbc_front.sv =====
module nbc_front #(
  parameter int MAX_CLASSES = nbc_pkg::MAX_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nbc_pkg::KIND_W-1:0]     in_kind,
  input  logic [nbc_pkg::LUMA_W-1:0]     in_y_value,
  input  logic [nbc_pkg::CHROMA_W-1:0]   in_u_value,
  input  logic [nbc_pkg::CHROMA_W-1:0]   in_v_value,
  input  logic [nbc_pkg::LABEL_W-1:0]    in_class_label,
  input  logic                           cfg_we,
  input  logic [nbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           init_busy,
  output nbc_pkg::cmd_t                  cmd,
  output logic                           cmd_valid,
  input  logic                           cmd_pop
);
  import nbc_pkg::*;

  logic [LUMA_W-1:0] y_upper_r, y_lower_r;
  logic [NCLS_W-1:0] class_count_r;
  logic [NCLS_W-1:0] ncls;
  logic              lab_err, in_win, push;
  cmd_t              new_cmd;
  cmd_t              q_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_upper_r     <= LUMA_W'(255);
      y_lower_r     <= '0;
      class_count_r <= NCLS_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_Y_UPPER:     y_upper_r <= cfg_data;
        CFG_Y_LOWER:     y_lower_r <= cfg_data;
        CFG_CLASS_COUNT: class_count_r <= cfg_data[NCLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign ncls    = (int'(class_count_r) > MAX_CLASSES) ? NCLS_W'(MAX_CLASSES) : class_count_r;
  assign lab_err = {1'b0, in_class_label} >= ncls;
  assign in_win  = (in_y_value >= y_lower_r) && (in_y_value <= y_upper_r);

  always_comb begin
    new_cmd             = '0;
    new_cmd.label       = in_class_label;
    new_cmd.u           = in_u_value;
    new_cmd.v           = in_v_value;
    new_cmd.ncls        = ncls;
    unique case (kind_t'(in_kind))
      KIND_CLEAR: new_cmd.op = OP_CLEAR;
      KIND_TRAIN: begin
        new_cmd.op          = OP_TRAIN;
        new_cmd.label_error = lab_err;
        new_cmd.counted     = !lab_err && in_win;
      end
      KIND_QUERY: new_cmd.op = OP_QUERY;
      default:    new_cmd.op = OP_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2) || init_busy;
  assign push      = in_valid && !in_stall;
  assign cmd       = q_r[rp_r];
  assign cmd_valid = cnt_r != 2'd0;
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, cmd_pop};

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (cmd_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/nbc_back.sv =====
module nbc_back #(
  parameter int MAX_CLASSES = nbc_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = nbc_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nbc_pkg::cmd_t                cmd,
  input  logic                         cmd_valid,
  output logic                         cmd_pop,
  output logic                         init_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_counted,
  output logic                         out_label_error,
  output logic                         out_class_found,
  output logic [nbc_pkg::LABEL_W-1:0]  out_class_index
);
  import nbc_pkg::*;

  localparam int W     = COUNT_BITS;
  localparam int CLS_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int IT_W  = CLS_W + 1;
  localparam int AW    = CLS_W + CHROMA_W;
  localparam int DEPTH = MAX_CLASSES * CHROMA_BINS;

  typedef enum logic [14:0] {
    S_INIT = 15'b000000000000001,
    S_IDLE = 15'b000000000000010,
    S_CLR  = 15'b000000000000100,
    S_TRD  = 15'b000000000001000,
    S_TWR  = 15'b000000000010000,
    S_QRD  = 15'b000000000100000,
    S_QMUL = 15'b000000001000000,
    S_QL0  = 15'b000000010000000,
    S_QL1  = 15'b000000100000000,
    S_QR0  = 15'b000001000000000,
    S_QR1  = 15'b000010000000000,
    S_QSUM = 15'b000100000000000,
    S_QCMP = 15'b001000000000000,
    S_TAKE = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  function automatic logic [W-1:0] sat_inc(input logic [W-1:0] x);
    return (x == '1) ? x : x + W'(1);
  endfunction

  state_t         state_r, state_nxt;
  cmd_t           cmd_r;
  logic [W-1:0]   u_mem [DEPTH];
  logic [W-1:0]   v_mem [DEPTH];
  logic [W-1:0]   u_rd_r, v_rd_r;
  logic [W-1:0]   tot_r [MAX_CLASSES];
  logic [AW-1:0]  clr_r;
  logic [IT_W-1:0] i_r;
  logic           found_r;
  logic [CLS_W-1:0] best_r;
  logic [W-1:0]   t_r, bt_r;
  logic [2*W-1:0] m_r, bp_r, p_r;
  logic [3*W-1:0] acc_r, lhs_r, rhs_r;
  logic [W-1:0]   mul_a, mul_b;
  logic [2*W-1:0] mul_p;
  logic           mem_we, rd_en, last, clr_done, skip, out_free, out_valid_r;
  logic [AW-1:0]  wa_u, wa_v, ra_u, ra_v;
  logic [W-1:0]   wd_u, wd_v;
  logic [CLS_W-1:0] lab_idx, it_idx;

  assign lab_idx   = CLS_W'(cmd_r.label);
  assign it_idx    = CLS_W'(i_r);
  assign init_busy = state_r == S_INIT;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign last      = (int'(i_r) + 1) >= int'(cmd_r.ncls);
  assign clr_done  = clr_r == AW'(DEPTH - 1);
  assign skip      = (u_rd_r == '0) || (v_rd_r == '0) || (t_r == '0);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // histogram ports
  assign mem_we = (state_r == S_INIT) || (state_r == S_CLR) || (state_r == S_TWR);
  assign wa_u   = (state_r == S_TWR) ? {lab_idx, cmd_r.u} : clr_r;
  assign wa_v   = (state_r == S_TWR) ? {lab_idx, cmd_r.v} : clr_r;
  assign wd_u   = (state_r == S_TWR) ? sat_inc(u_rd_r) : '0;
  assign wd_v   = (state_r == S_TWR) ? sat_inc(v_rd_r) : '0;
  assign rd_en  = (state_r == S_TRD) || (state_r == S_QRD);
  assign ra_u   = {(state_r == S_TRD) ? lab_idx : it_idx, cmd_r.u};
  assign ra_v   = {(state_r == S_TRD) ? lab_idx : it_idx, cmd_r.v};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      u_mem[wa_u] <= wd_u;
      v_mem[wa_v] <= wd_v;
    end
    if (rd_en) begin
      u_rd_r <= u_mem[ra_u];
      v_rd_r <= v_mem[ra_v];
    end
  end

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_QMUL:  begin mul_a = u_rd_r;         mul_b = v_rd_r; end
      S_QL0:   begin mul_a = m_r[W-1:0];     mul_b = bt_r;   end
      S_QL1:   begin mul_a = m_r[2*W-1:W];   mul_b = bt_r;   end
      S_QR0:   begin mul_a = bp_r[W-1:0];    mul_b = t_r;    end
      S_QR1:   begin mul_a = bp_r[2*W-1:W];  mul_b = t_r;    end
      default: begin mul_a = '0;             mul_b = '0;     end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_CLEAR: state_nxt = S_CLR;
            OP_TRAIN: state_nxt = cmd.counted ? S_TRD : S_OUT;
            OP_QUERY: state_nxt = (cmd.ncls == '0) ? S_OUT : S_QRD;
            default:  state_nxt = S_OUT;
          endcase
        end
      end
      S_CLR:  if (clr_done) state_nxt = S_OUT;
      S_TRD:  state_nxt = S_TWR;
      S_TWR:  state_nxt = S_OUT;
      S_QRD:  state_nxt = S_QMUL;
      S_QMUL: begin
        if (skip) state_nxt = last ? S_OUT : S_QRD;
        else      state_nxt = found_r ? S_QL0 : S_TAKE;
      end
      S_QL0:  state_nxt = S_QL1;
      S_QL1:  state_nxt = S_QR0;
      S_QR0:  state_nxt = S_QR1;
      S_QR1:  state_nxt = S_QSUM;
      S_QSUM: state_nxt = S_QCMP;
      S_QCMP: begin
        if (lhs_r > rhs_r) state_nxt = S_TAKE;
        else               state_nxt = last ? S_OUT : S_QRD;
      end
      S_TAKE: state_nxt = last ? S_OUT : S_QRD;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      i_r         <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_CLASSES; k++) tot_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT || state_r == S_CLR) begin
        clr_r <= clr_done ? '0 : clr_r + AW'(1);
      end
      if (cmd_pop) begin
        i_r     <= '0;
        found_r <= 1'b0;
        if (cmd.op == OP_CLEAR) begin
          for (int k = 0; k < MAX_CLASSES; k++) tot_r[k] <= '0;
        end
      end
      if (state_r == S_TWR) begin
        tot_r[lab_idx] <= sat_inc(tot_r[lab_idx]);
      end
      if (state_r == S_TAKE) begin
        found_r <= 1'b1;
      end
      if ((state_r == S_TAKE) || (state_r == S_QMUL && skip) ||
          (state_r == S_QCMP && !(lhs_r > rhs_r))) begin
        i_r <= i_r + IT_W'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r  <= cmd;
      best_r <= '0;
    end
    if (state_r == S_QRD) t_r <= tot_r[it_idx];
    if (state_r == S_QMUL) m_r <= mul_p;
    if (state_r == S_QL0) p_r <= mul_p;
    if (state_r == S_QL1) begin
      acc_r <= {{W{1'b0}}, p_r};
      p_r   <= mul_p;
    end
    if (state_r == S_QR0) begin
      lhs_r <= acc_r + {p_r, {W{1'b0}}};
      p_r   <= mul_p;
    end
    if (state_r == S_QR1) begin
      acc_r <= {{W{1'b0}}, p_r};
      p_r   <= mul_p;
    end
    if (state_r == S_QSUM) rhs_r <= acc_r + {p_r, {W{1'b0}}};
    if (state_r == S_TAKE) begin
      best_r <= it_idx;
      bp_r   <= m_r;
      bt_r   <= t_r;
    end
    if (state_r == S_OUT && out_free) begin
      out_counted     <= (cmd_r.op == OP_TRAIN) && cmd_r.counted;
      out_label_error <= (cmd_r.op == OP_TRAIN) && cmd_r.label_error;
      out_class_found <= (cmd_r.op == OP_QUERY) && found_r;
      out_class_index <= ((cmd_r.op == OP_QUERY) && found_r) ? LABEL_W'(best_r) : '0;
    end
  end

endmodule

// ===== sv/naive_bayes_uv_color_classifier.sv =====
// Naive Bayes chroma classifier.
// Input channel (in_valid/in_stall) carries one item: kind 0 clears all
// counts, kind 1 trains on a labelled pixel, kind 2 queries a (U,V) pair.
// Each item gives exactly one result item on out_valid/out_stall.
// Config (cfg_we/cfg_index/cfg_data): 0 y_upper, 1 y_lower, 2 class_count;
// write only while the block is idle.
// A two-entry command queue sits between the decoder and the executor, and
// the result sits in an output register, so a stalled output does not
// block new items until the queue fills.
// In the executor a query steps through each class in use in turn, with
// the one shared multiplier that forms the cross products cU*cV*bestT and
// bestU*bestV*T; a clear sweeps all MAX_CLASSES*256 histogram entries.
// After reset the histogram memories are swept to zero in the same way;
// in_stall stays high during the sweep. While out_stall is high the
// result waits in the output register and the executor holds.
module naive_bayes_uv_color_classifier #(
  parameter int MAX_CLASSES = nbc_pkg::MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = nbc_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nbc_pkg::KIND_W-1:0]     in_kind,
  input  logic [nbc_pkg::LUMA_W-1:0]     in_y_value,
  input  logic [nbc_pkg::CHROMA_W-1:0]   in_u_value,
  input  logic [nbc_pkg::CHROMA_W-1:0]   in_v_value,
  input  logic [nbc_pkg::LABEL_W-1:0]    in_class_label,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_counted,
  output logic                           out_label_error,
  output logic                           out_class_found,
  output logic [nbc_pkg::LABEL_W-1:0]    out_class_index,
  input  logic                           cfg_we,
  input  logic [nbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nbc_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop, init_busy;

  nbc_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_y_value, .in_u_value,
    .in_v_value, .in_class_label, .cfg_we, .cfg_index, .cfg_data,
    .init_busy, .cmd, .cmd_valid, .cmd_pop
  );

  nbc_back #(.MAX_CLASSES(MAX_CLASSES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .cmd, .cmd_valid, .cmd_pop, .init_busy, .out_valid,
    .out_stall, .out_counted, .out_label_error, .out_class_found,
    .out_class_index
  );

endmodule

// ===== bench/nbc_score_checker.sv =====
`timescale 1ns / 1ps

module nbc_score_checker
  import nbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [LUMA_W-1:0]     in_y_value,
  input  logic [CHROMA_W-1:0]   in_u_value,
  input  logic [CHROMA_W-1:0]   in_v_value,
  input  logic [LABEL_W-1:0]    in_class_label,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_counted,
  input  logic                  out_label_error,
  input  logic                  out_class_found,
  input  logic [LABEL_W-1:0]    out_class_index,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    outstanding,
  output int                    fails
);

  typedef struct packed {
    logic               counted;
    logic               label_error;
    logic               class_found;
    logic [LABEL_W-1:0] class_index;
  } verdict_t;

  logic [31:0] u_hist [MAX_CLASSES_DEF][CHROMA_BINS];
  logic [31:0] v_hist [MAX_CLASSES_DEF][CHROMA_BINS];
  logic [31:0] totals [MAX_CLASSES_DEF];
  logic [LUMA_W-1:0] y_hi, y_lo;
  logic [NCLS_W-1:0] ncls_reg;
  verdict_t pending_verdicts[$];

  assign outstanding = pending_verdicts.size();

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic void wipe_counts();
    for (int c = 0; c < MAX_CLASSES_DEF; c++) begin
      totals[c] = '0;
      for (int b = 0; b < CHROMA_BINS; b++) begin
        u_hist[c][b] = '0;
        v_hist[c][b] = '0;
      end
    end
  endfunction

  // updates the class model and returns the verdict for one item
  function automatic verdict_t classify_item(input kind_t k, input logic [7:0] y,
                                             input logic [7:0] u, input logic [7:0] v,
                                             input logic [3:0] lab);
    verdict_t r;
    int n;
    logic found;
    logic [31:0] bu, bv, bt, cu, cv, t;
    logic [3:0] best;
    r = '0;
    n = (ncls_reg > MAX_CLASSES_DEF) ? MAX_CLASSES_DEF : int'(ncls_reg);
    case (k)
      KIND_CLEAR: wipe_counts();
      KIND_TRAIN: begin
        if (int'(lab) >= n) begin
          r.label_error = 1'b1;
        end else if (y >= y_lo && y <= y_hi) begin
          totals[lab] = bump(totals[lab]);
          u_hist[lab][u] = bump(u_hist[lab][u]);
          v_hist[lab][v] = bump(v_hist[lab][v]);
          r.counted = 1'b1;
        end
      end
      KIND_QUERY: begin
        found = 1'b0;
        best = '0;
        bu = '0;
        bv = '0;
        bt = 32'd1;
        for (int c = 0; c < n; c++) begin
          t = totals[c];
          cu = u_hist[c][u];
          cv = v_hist[c][v];
          if (t != 0 && cu != 0 && cv != 0) begin
            if (!found || 128'(cu) * 128'(cv) * 128'(bt) > 128'(bu) * 128'(bv) * 128'(t)) begin
              found = 1'b1;
              best = c[3:0];
              bu = cu;
              bv = cv;
              bt = t;
            end
          end
        end
        r.class_found = found;
        r.class_index = found ? best : '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    verdict_t e;
    int errs;
    if (!rst_n) begin
      y_hi <= 8'd255;
      y_lo <= 8'd0;
      ncls_reg <= 5'd16;
      wipe_counts();
      pending_verdicts.delete();
      fails <= 0;
    end else begin
      errs = 0;
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $error("result item with nothing expected");
          errs++;
        end else begin
          e = pending_verdicts.pop_front();
          if (out_counted !== e.counted) begin
            $error("counted: expected %0d actual %0d", e.counted, out_counted);
            errs++;
          end
          if (out_label_error !== e.label_error) begin
            $error("label_error: expected %0d actual %0d", e.label_error, out_label_error);
            errs++;
          end
          if (out_class_found !== e.class_found) begin
            $error("class_found: expected %0d actual %0d", e.class_found, out_class_found);
            errs++;
          end
          if (out_class_index !== e.class_index) begin
            $error("class_index: expected %0d actual %0d", e.class_index, out_class_index);
            errs++;
          end
        end
      end
      fails <= fails + errs;
      if (in_valid && !in_stall)
        pending_verdicts.push_back(classify_item(kind_t'(in_kind), in_y_value, in_u_value,
                                                 in_v_value, in_class_label));
      if (cfg_we) begin
        case (cfg_index)
          CFG_Y_UPPER:     y_hi <= cfg_data;
          CFG_Y_LOWER:     y_lo <= cfg_data;
          CFG_CLASS_COUNT: ncls_reg <= cfg_data[NCLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import nbc_pkg::*;

  localparam int QUIET_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [LUMA_W-1:0] in_y_value = '0;
  logic [CHROMA_W-1:0] in_u_value = '0;
  logic [CHROMA_W-1:0] in_v_value = '0;
  logic [LABEL_W-1:0] in_class_label = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_counted, out_label_error, out_class_found;
  logic [LABEL_W-1:0] out_class_index;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int outstanding, fails;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  logic [7:0] u_pool [4];
  logic [7:0] v_pool [4];

  always #10 clk = ~clk;

  naive_bayes_uv_color_classifier dut (.*);

  nbc_score_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(input kind_t k, input logic [7:0] y, input logic [7:0] u,
                           input logic [7:0] v, input logic [3:0] lab);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_y_value <= y;
    in_u_value <= u;
    in_v_value <= v;
    in_class_label <= lab;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic setup_phase(input logic [7:0] hi, input logic [7:0] lo,
                             input logic [4:0] ncls, input int idle, input int stall);
    drain();
    write_reg(CFG_Y_UPPER, hi);
    write_reg(CFG_Y_LOWER, lo);
    write_reg(CFG_CLASS_COUNT, {3'b000, ncls});
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < 4; i++) begin
      u_pool[i] = 8'($urandom);
      v_pool[i] = 8'($urandom);
    end
  endtask

  task automatic random_items(input int count);
    int r;
    kind_t k;
    logic [7:0] u, v;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(999);
      if (r < 8) k = KIND_CLEAR;
      else if (r < 30) k = KIND_NONE;
      else if (r < 560) k = KIND_TRAIN;
      else k = KIND_QUERY;
      u = ($urandom_range(9) < 7) ? u_pool[$urandom_range(3)] : 8'($urandom);
      v = ($urandom_range(9) < 7) ? v_pool[$urandom_range(3)] : 8'($urandom);
      send_item(k, 8'($urandom), u, v, 4'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(KIND_QUERY, 8'd0, 8'd0, 8'd0, 4'd0);
    send_item(KIND_TRAIN, 8'd0, 8'd0, 8'd255, 4'd0);
    send_item(KIND_TRAIN, 8'd255, 8'd255, 8'd0, 4'd15);
    send_item(KIND_QUERY, 8'd0, 8'd0, 8'd255, 4'd0);
    send_item(KIND_QUERY, 8'd0, 8'd255, 8'd0, 4'd0);
    send_item(KIND_QUERY, 8'd0, 8'd0, 8'd0, 4'd0);
    send_item(KIND_TRAIN, 8'd10, 8'd77, 8'd88, 4'd2);
    send_item(KIND_TRAIN, 8'd10, 8'd77, 8'd88, 4'd5);
    send_item(KIND_QUERY, 8'd0, 8'd77, 8'd88, 4'd0);
    send_item(KIND_TRAIN, 8'd10, 8'd77, 8'd88, 4'd5);
    send_item(KIND_QUERY, 8'd0, 8'd77, 8'd88, 4'd0);
    send_item(KIND_NONE, 8'd255, 8'd255, 8'd255, 4'd15);
    send_item(KIND_CLEAR, 8'd0, 8'd0, 8'd0, 4'd0);
    send_item(KIND_QUERY, 8'd0, 8'd77, 8'd88, 4'd0);
    random_items(110);

    // class count above the limit, then empty window, then single class with one luma, then no class in use
    setup_phase(8'd180, 8'd40, 5'd31, 81, 0);
    send_item(KIND_TRAIN, 8'd40, 8'd1, 8'd2, 4'd15);
    send_item(KIND_TRAIN, 8'd39, 8'd1, 8'd2, 4'd3);
    send_item(KIND_TRAIN, 8'd181, 8'd1, 8'd2, 4'd3);
    random_items(110);
    setup_phase(8'd100, 8'd200, 5'd16, 0, 81);
    send_item(KIND_TRAIN, 8'd150, 8'd1, 8'd2, 4'd1);
    random_items(100);
    setup_phase(8'd255, 8'd255, 5'd1, 9, 9);
    send_item(KIND_TRAIN, 8'd255, 8'd9, 8'd9, 4'd0);
    send_item(KIND_TRAIN, 8'd255, 8'd9, 8'd9, 4'd1);
    send_item(KIND_QUERY, 8'd0, 8'd9, 8'd9, 4'd0);
    random_items(100);
    setup_phase(8'd0, 8'd0, 5'd0, 81, 81);
    send_item(KIND_TRAIN, 8'd0, 8'd9, 8'd9, 4'd0);
    send_item(KIND_QUERY, 8'd0, 8'd9, 8'd9, 4'd0);
    random_items(90);
    setup_phase(8'd200, 8'd20, 5'd7, 0, 0);
    random_items(110);

    drain();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nbc_pkg.sv
sv/nbc_front.sv
sv/nbc_back.sv
sv/naive_bayes_uv_color_classifier.sv
bench/nbc_score_checker.sv
bench/tb_top.sv
